[rtl/cgd_pkg.sv]
// shared constants for the cell growth and division step block
`timescale 1ns / 1ps

package cgd_pkg;

    // field widths
    localparam int MODE_W  = 2;
    localparam int DT_W    = 24;
    localparam int SUB_W   = 32;
    localparam int RATE_W  = 40;
    localparam int LEN_W   = 40;
    localparam int WGT_W   = 32;
    localparam int AGE_W   = 32;
    localparam int UPT_W   = 40;
    localparam int CONS_W  = 57;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 3;

    // shared multiplier geometry
    localparam int MA_W   = 56;
    localparam int MB_W   = 48;
    localparam int DIG_W  = 16;
    localparam int ACC_W  = MA_W + MB_W;
    localparam int PROD_W = MA_W + DIG_W;

    // item modes
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIVIDE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YXS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_METAB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZTHR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DTHR  = 3'd6;

    // register reset values
    localparam logic [31:0] KS_RST    = 32'd167772;
    localparam logic [15:0] YXS_RST   = 16'd32768;
    localparam logic [39:0] LEN_RST   = 40'd1832402098;
    localparam logic [31:0] METAB_RST = 32'd1193046;
    localparam logic [31:0] IDT_RST   = 32'd13273858;
    localparam logic [31:0] ZTHR_RST  = 32'd0;
    localparam logic [31:0] DTHR_RST  = 32'd1678;

    // multiplier operation codes, in issue order
    typedef logic [2:0] t_op;
    localparam t_op OP_TGT  = 3'd0;
    localparam t_op OP_A    = 3'd1;
    localparam t_op OP_B    = 3'd2;
    localparam t_op OP_GAIN = 3'd3;
    localparam t_op OP_K    = 3'd4;
    localparam t_op OP_DEC  = 3'd5;
    localparam t_op OP_UPT  = 3'd6;
    localparam t_op OP_MAG  = 3'd7;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // multiply sub-steps: load, three digits, writeback
    localparam logic [2:0] MC_LOAD = 3'd0;
    localparam logic [2:0] MC_WB   = 3'd4;

endpackage

[rtl/cell_growth_division_step.sv]
// cell growth and division step: top level with divider, shared multiplier and sequencer
// a time step: the divider forms the Monod ratio, then eight multiplies run in issue order
// (each multiply loads, accumulates digits and writes back), then the result is registered
// start, divide, skipped steps and the unused mode run only the magnitude multiply
// one transaction in work at a time; a stalled output register holds the sequencer
// synchronous active-low reset clears state, sequencer and valids; registers take defaults
`timescale 1ns / 1ps

module cell_growth_division_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [cgd_pkg::MODE_W-1:0]     i_mode,
    input  logic [cgd_pkg::DT_W-1:0]       i_time_step,
    input  logic [cgd_pkg::SUB_W-1:0]      i_substrate,
    input  logic [cgd_pkg::RATE_W-1:0]     i_start_growth_rate,
    input  logic [cgd_pkg::LEN_W-1:0]      i_start_length,
    input  logic [cgd_pkg::WGT_W-1:0]      i_weight,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [cgd_pkg::RATE_W-1:0]     o_growth_rate,
    output logic [cgd_pkg::LEN_W-1:0]      o_cell_length,
    output logic [cgd_pkg::AGE_W-1:0]      o_cell_age,
    output logic [cgd_pkg::UPT_W-1:0]      o_uptake_rate,
    output logic signed [cgd_pkg::CONS_W-1:0] o_consumption,
    output logic                           o_division_due,
    output logic                           o_step_skipped
);
    import cgd_pkg::*;

    // configuration registers
    logic [31:0] r_ks, r_metab, r_idt, r_zthr, r_dthr;
    logic [15:0] r_yxs;
    logic [39:0] r_lenf;

    // cell state
    logic [RATE_W-1:0] r_rate;
    logic [LEN_W-1:0]  r_len;
    logic [AGE_W-1:0]  r_age;
    logic [UPT_W-1:0]  r_upt;

    // latched item
    logic [DT_W-1:0]  r_dt;
    logic [SUB_W-1:0] r_sub;
    logic [WGT_W-1:0] r_wgt;
    logic             r_due, r_skip;

    // sequencer
    logic [1:0] r_state;
    t_op        r_op;
    logic [2:0] r_mcnt;
    logic [4:0] r_dcnt;

    // divider
    logic [32:0] r_d, r_rem;
    logic [31:0] r_q;
    logic        r_qtop;
    logic [33:0] w_dshift, w_dsub;
    logic        w_dge;
    logic [32:0] w_ratio;

    // multiplier
    logic [MA_W-1:0]   r_ma, w_opa;
    logic [MB_W-1:0]   r_mb, w_opb;
    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0] w_prod;
    logic [MA_W-1:0]   w_res;

    // intermediates
    logic [39:0] r_tgt, r_a;
    logic [47:0] r_b, r_gain;
    logic [55:0] r_k, r_mag;

    // step update terms
    logic [32:0] w_age_sum;
    logic [AGE_W-1:0] w_age_new;
    logic [47:0] w_len_room;
    logic        w_acc_item;
    logic        w_skip_in;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc_item = i_in_valid && o_in_ready;
    assign w_skip_in  = (i_mode == MODE_STEP) && (i_substrate <= r_zthr);

    // divider datapath
    assign w_dshift = {r_rem, 1'b0};
    assign w_dsub   = w_dshift - {1'b0, r_d};
    assign w_dge    = (w_dshift >= {1'b0, r_d});
    assign w_ratio  = {r_qtop, r_q};

    // multiplier datapath: one 16-bit digit of b per cycle, msb first
    assign w_prod = r_ma * r_mb[MB_W-1:MB_W-DIG_W];

    // operand select per operation
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (r_op)
            OP_TGT:  begin w_opa = {16'd0, r_rate};  w_opb = {15'd0, w_ratio}; end
            OP_A:    begin w_opa = {32'd0, r_dt};    w_opb = {32'd0, r_yxs}; end
            OP_B:    begin w_opa = {16'd0, r_rate};  w_opb = {8'd0, r_a}; end
            OP_GAIN: begin w_opa = {16'd0, r_lenf};  w_opb = r_b; end
            OP_K:    begin w_opa = {24'd0, r_metab}; w_opb = {24'd0, r_dt}; end
            OP_DEC:  begin w_opa = r_k;              w_opb = {8'd0, r_rate - r_tgt}; end
            OP_UPT:  begin w_opa = {16'd0, r_rate};  w_opb = {15'd0, w_ratio}; end
            OP_MAG:  begin w_opa = {24'd0, r_wgt};   w_opb = {8'd0, r_upt}; end
            default: begin w_opa = '0;               w_opb = '0; end
        endcase
    end

    // result scaling per operation
    always_comb begin
        case (r_op)
            OP_TGT, OP_B, OP_UPT: w_res = r_acc[32 +: MA_W];
            OP_GAIN:              w_res = r_acc[40 +: MA_W];
            OP_DEC:               w_res = r_acc[48 +: MA_W];
            OP_MAG:               w_res = r_acc[16 +: MA_W];
            default:              w_res = r_acc[MA_W-1:0];
        endcase
    end

    // age and length update terms
    assign w_age_sum  = {1'b0, r_age} + {13'd0, r_dt[DT_W-1:4]};
    assign w_age_new  = w_age_sum[32] ? {AGE_W{1'b1}} : w_age_sum[AGE_W-1:0];
    assign w_len_room = {8'd0, {LEN_W{1'b1}}} - {8'd0, r_len};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks    <= KS_RST;
            r_yxs   <= YXS_RST;
            r_lenf  <= LEN_RST;
            r_metab <= METAB_RST;
            r_idt   <= IDT_RST;
            r_zthr  <= ZTHR_RST;
            r_dthr  <= DTHR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KS:    r_ks    <= i_cfg_data[31:0];
                REG_YXS:   r_yxs   <= i_cfg_data[15:0];
                REG_LEN:   r_lenf  <= i_cfg_data[39:0];
                REG_METAB: r_metab <= i_cfg_data[31:0];
                REG_IDT:   r_idt   <= i_cfg_data[31:0];
                REG_ZTHR:  r_zthr  <= i_cfg_data[31:0];
                REG_DTHR:  r_dthr  <= i_cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    // sequencer, state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_MAG;
            r_mcnt      <= MC_LOAD;
            r_dcnt      <= '0;
            r_rate      <= '0;
            r_len       <= '0;
            r_age       <= '0;
            r_upt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && r_state != ST_FIN) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_item) begin
                        r_dt   <= i_time_step;
                        r_sub  <= i_substrate;
                        r_wgt  <= i_weight;
                        r_due  <= 1'b0;
                        r_skip <= w_skip_in;
                        r_mcnt <= MC_LOAD;
                        r_op   <= OP_MAG;
                        r_state <= (i_mode == MODE_STEP && !w_skip_in) ? ST_DIV : ST_MUL;
                        case (i_mode)
                            MODE_START: begin
                                r_age  <= '0;
                                r_upt  <= '0;
                                r_rate <= i_start_growth_rate;
                                r_len  <= i_start_length;
                            end
                            MODE_STEP: begin
                                if (!w_skip_in) begin
                                    r_d     <= {1'b0, r_ks} + {1'b0, i_substrate};
                                    r_rem   <= (r_ks == '0) ? 33'd0 : {1'b0, i_substrate};
                                    r_qtop  <= (r_ks == '0);
                                    r_q     <= '0;
                                    r_dcnt  <= '0;
                                end
                            end
                            MODE_DIVIDE: begin
                                r_age <= '0;
                                r_len <= {1'b0, r_len[LEN_W-1:1]};
                            end
                            default: ;
                        endcase
                    end
                end
                // one quotient bit per cycle
                ST_DIV: begin
                    r_rem  <= w_dge ? w_dsub[32:0] : w_dshift[32:0];
                    r_q    <= {r_q[30:0], w_dge};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_op    <= OP_TGT;
                        r_mcnt  <= MC_LOAD;
                        r_state <= ST_MUL;
                    end
                end
                // load, three digit steps, writeback
                ST_MUL: begin
                    if (r_mcnt == MC_LOAD) begin
                        r_mcnt <= r_mcnt + 3'd1;
                        r_ma   <= w_opa;
                        r_mb   <= w_opb;
                        r_acc  <= '0;
                    end else if (r_mcnt != MC_WB) begin
                        r_mcnt <= r_mcnt + 3'd1;
                        r_acc  <= {r_acc[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}}
                                  + {{(ACC_W-PROD_W){1'b0}}, w_prod};
                        r_mb   <= {r_mb[MB_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    end else begin
                        r_mcnt <= MC_LOAD;
                        r_op   <= r_op + 3'd1;
                        case (r_op)
                            OP_TGT:  r_tgt  <= w_res[39:0];
                            OP_A:    r_a    <= w_res[39:0];
                            OP_B:    r_b    <= w_res[47:0];
                            OP_GAIN: r_gain <= w_res[47:0];
                            OP_K:    r_k    <= w_res[55:0];
                            OP_DEC: begin
                                r_rate <= (w_res[47:0] >= {8'd0, r_rate})
                                          ? '0 : r_rate - w_res[39:0];
                                r_len  <= (r_gain >= w_len_room)
                                          ? {LEN_W{1'b1}} : r_len + r_gain[39:0];
                                r_age  <= w_age_new;
                                r_due  <= (r_idt < w_age_new) && (r_sub > r_dthr);
                            end
                            OP_UPT:  r_upt  <= w_res[39:0];
                            OP_MAG: begin
                                r_mag   <= w_res[55:0];
                                r_state <= ST_FIN;
                            end
                            default: ;
                        endcase
                    end
                end
                // hand the result to the output register once it is free
                ST_FIN: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid    <= 1'b1;
                        o_growth_rate  <= r_rate;
                        o_cell_length  <= r_len;
                        o_cell_age     <= r_age;
                        o_uptake_rate  <= r_upt;
                        o_consumption  <= ~{1'b0, r_mag} + 57'd1;
                        o_division_due <= r_due;
                        o_step_skipped <= r_skip;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/cgd_checker.sv]
// port-level checker for the cell growth and division step, with its bind
`timescale 1ns / 1ps

module cgd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [cgd_pkg::AGE_W-1:0]       o_cell_age,
    input logic signed [cgd_pkg::CONS_W-1:0] o_consumption,
    input logic                            o_division_due,
    input logic                            o_step_skipped
);
    import cgd_pkg::*;

    // a held result stays valid and keeps its cell age
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_age))
        else $error("held result changed");

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // consumption is never positive
    a_cons_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_consumption[CONS_W-1] || o_consumption == '0))
        else $error("positive consumption");

    // a skipped step never reports division
    a_skip_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_step_skipped |-> !o_division_due)
        else $error("division on skipped step");

endmodule

bind cell_growth_division_step cgd_checker u_cgd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_cell_age     (o_cell_age),
    .o_consumption  (o_consumption),
    .o_division_due (o_division_due),
    .o_step_skipped (o_step_skipped)
);
